// File: design/gpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the grid path counter.
package gpc_pkg;

	localparam int PATH_W = 64;
	localparam int ROWS_W = 16;
	localparam int COLS_W = 8;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 1;

	localparam logic [IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [IDX_W-1:0] REG_COLS = 1'b1;

	typedef struct packed {
		logic [PATH_W-1:0] count;
		logic              sat;
	} res_t;

	typedef logic [1:0] occ_t;

endpackage

// File: design/gpc_row_mem.sv
`timescale 1ns / 1ps
// Row buffer: one write port, one registered read port.
module gpc_row_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the old word on a same-address write; caller forwards
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: design/gpc_out_fifo.sv
`timescale 1ns / 1ps
// Two-entry result queue that decouples the output stall from the datapath.
module gpc_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gpc_pkg::res_t  push_data,
	input  logic           pop,
	output gpc_pkg::res_t  head,
	output gpc_pkg::occ_t  occ
);

	gpc_pkg::res_t e0_q, e1_q;
	gpc_pkg::occ_t occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else if (push && !pop) begin
			occ_q <= occ_q + 2'd1;
		end else if (pop && !push) begin
			occ_q <= occ_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && push) begin
			if (occ_q == 2'd1) begin
				e0_q <= push_data;
			end else begin
				e0_q <= e1_q;
				e1_q <= push_data;
			end
		end else if (pop) begin
			e0_q <= e1_q;
		end else if (push) begin
			if (occ_q == 2'd0) begin
				e0_q <= push_data;
			end else begin
				e1_q <= push_data;
			end
		end
	end

	assign head = e0_q;
	assign occ  = occ_q;

endmodule

// File: design/grid_path_count_with_obstacles_top.sv
`timescale 1ns / 1ps
// Grid path counter top level: cell sequencing, count datapath, row buffer.
// Takes one cell (a blocked bit) per cycle in row-major order while not stalled,
// and queues the path count of a grid once its last cell has passed stage one.
// The rate is set by the row buffer: each cell does one read and one write of
// its column entry and one saturating add of the counts above and to the left;
// the just-written count is forwarded when a one-column grid reads it back at
// once. Results queue in a two-entry buffer; input stalls only when that buffer
// could overflow, and a result taken in the same cycle frees its slot at once.
// Writing grid_rows or grid_cols restarts the grid; write them only while idle.
// The row buffer needs no clearing pass after reset.
module grid_path_count_with_obstacles_top #(
	parameter int MAX_COLS   = 128,
	parameter int COUNT_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gpc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gpc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         blocked,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gpc_pkg::PATH_W-1:0]   path_count,
	output logic                         saturated
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int LIM_W = 13;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [gpc_pkg::ROWS_W-1:0] rows_q;
	logic [gpc_pkg::COLS_W-1:0] cols_q;
	logic [COL_W-1:0]           col_q;
	logic [gpc_pkg::ROWS_W-1:0] row_q;

	logic [LIM_W-1:0]           cols_ext, cols_eff;
	logic [COL_W-1:0]           last_col;
	logic [gpc_pkg::ROWS_W-1:0] last_row;
	logic                       at_last_col, at_last_row, accept;

	logic                  valid_s1, blk_s1, col0_s1, row0_s1, last_s1, fwd_s1;
	logic [COL_W-1:0]      col_s1;
	logic [COUNT_BITS-1:0] fwd_data_s1;
	logic [COUNT_BITS-1:0] left_q;
	logic                  clip_q;

	logic [COUNT_BITS-1:0] rd_data, above, left, cnt;
	logic [COUNT_BITS:0]   sum;
	logic                  carry, clip_now;

	gpc_pkg::res_t res, head;
	gpc_pkg::occ_t occ;
	logic          push, pop;

	// effective geometry: zero means one, columns clip at the buffer depth
	always_comb begin
		cols_ext = LIM_W'(cols_q);
		cols_eff = cols_ext;
		if (cols_ext == '0) begin
			cols_eff = LIM_W'(1);
		end else if (cols_ext > LIM_W'(MAX_COLS)) begin
			cols_eff = LIM_W'(MAX_COLS);
		end
		last_col = COL_W'(cols_eff - LIM_W'(1));
		last_row = (rows_q == '0) ? '0 : rows_q - 1'b1;
	end

	assign at_last_col = (col_q == last_col);
	assign at_last_row = (row_q == last_row);
	assign accept      = in_valid && !in_stall;

	// a cell that ends a grid needs a free queue slot in the next cycle
	assign push     = valid_s1 && last_s1;
	assign in_stall = ((occ == 2'd2) && (push || !pop)) || ((occ == 2'd1) && push && !pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gpc_pkg::ROWS_W'(1);
			cols_q <= gpc_pkg::COLS_W'(1);
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
			case (cfg_index)
				gpc_pkg::REG_ROWS: rows_q <= cfg_data[gpc_pkg::ROWS_W-1:0];
				gpc_pkg::REG_COLS: cols_q <= cfg_data[gpc_pkg::COLS_W-1:0];
				default: ;
			endcase
		end else if (accept) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			clip_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			// previous cell writes the entry this cell is reading
			fwd_s1   <= valid_s1 && (col_s1 == col_q);
			if (cfg_we) begin
				clip_q <= 1'b0;
			end else if (valid_s1) begin
				clip_q <= last_s1 ? 1'b0 : (clip_q | clip_now);
			end
		end
	end

	always_ff @(posedge clk) begin
		blk_s1      <= blocked;
		col0_s1     <= (col_q == '0);
		row0_s1     <= (row_q == '0);
		last_s1     <= at_last_col && at_last_row;
		col_s1      <= col_q;
		fwd_data_s1 <= cnt;
		if (valid_s1) begin
			left_q <= cnt;
		end
	end

	gpc_row_mem #(
		.DEPTH (MAX_COLS),
		.WIDTH (COUNT_BITS),
		.AW    (COL_W)
	) u_mem (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (cnt),
		.raddr (col_q),
		.rdata (rd_data)
	);

	always_comb begin
		above    = row0_s1 ? '0 : (fwd_s1 ? fwd_data_s1 : rd_data);
		left     = col0_s1 ? '0 : left_q;
		sum      = {1'b0, above} + {1'b0, left};
		carry    = sum[COUNT_BITS];
		clip_now = 1'b0;
		if (blk_s1) begin
			cnt = '0;
		end else if (row0_s1 && col0_s1) begin
			cnt = COUNT_BITS'(1);
		end else begin
			cnt      = carry ? COUNT_MAX : sum[COUNT_BITS-1:0];
			clip_now = carry;
		end
	end

	assign res.count = gpc_pkg::PATH_W'(cnt);
	assign res.sat   = clip_q | clip_now;
	assign pop       = out_valid && !out_stall;

	gpc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.pop       (pop),
		.head      (head),
		.occ       (occ)
	);

	assign out_valid  = (occ != 2'd0);
	assign path_count = head.count;
	assign saturated  = head.sat;

endmodule

// File: design/gpc_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the grid path counter, bound to the top level.
module gpc_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [gpc_pkg::PATH_W-1:0] path_count,
	input logic                       saturated
);

	// input backs up only behind a waiting result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// a result rising out of an empty queue follows a beat that closed a grid
	a_result_follows_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a closing cell");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(path_count) && $stable(saturated)))
		else $error("stalled result changed");

endmodule

bind grid_path_count_with_obstacles_top gpc_chk u_gpc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.path_count (path_count),
	.saturated  (saturated)
);

// File: dv/grid_path_count_with_obstacles_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the grid path counter: directed grids, then random grids.
module grid_path_count_with_obstacles_top_tb;

	localparam int PATH_W       = gpc_pkg::PATH_W;
	localparam int ROWS_W       = gpc_pkg::ROWS_W;
	localparam int COLS_W       = gpc_pkg::COLS_W;
	localparam int CFG_W        = gpc_pkg::CFG_W;
	localparam int IDX_W        = gpc_pkg::IDX_W;

	localparam int MAX_COLS     = 128;
	localparam int COUNT_BITS   = 64;
	localparam int DRAIN_CYCLES = 6;
	localparam int RAND_BEATS   = 250;
	localparam longint TIMEOUT_NS = 2_000_000;
	localparam logic [PATH_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		bit                wr;
		logic [15:0]       rows;
		logic [15:0]       cols;
		logic [15:0]       cells;     // blocked bits of the first 16 cells, first cell in bit 0
		bit                last_blk;
		logic [15:0]       cut;       // nonzero: abandon the grid after this many cells
		bit                known;
		logic [PATH_W-1:0] cnt;
		logic              sat;
	} grid_case_t;

	localparam int N_CASES = 20;
	localparam grid_case_t GRID_CASES [N_CASES] = '{
		'{1'b0, 16'd1,     16'd1,      16'h0000, 1'b0, 16'd0, 1'b1, 64'd1,    1'b0},
		'{1'b0, 16'd1,     16'd1,      16'h0001, 1'b0, 16'd0, 1'b1, 64'd0,    1'b0},
		'{1'b1, 16'd0,     16'd0,      16'h0000, 1'b0, 16'd0, 1'b1, 64'd1,    1'b0},
		'{1'b1, 16'd3,     16'd3,      16'h0000, 1'b0, 16'd0, 1'b1, 64'd6,    1'b0},
		'{1'b0, 16'd3,     16'd3,      16'h0001, 1'b0, 16'd0, 1'b1, 64'd0,    1'b0},
		'{1'b0, 16'd3,     16'd3,      16'h0100, 1'b0, 16'd0, 1'b1, 64'd0,    1'b0},
		'{1'b0, 16'd3,     16'd3,      16'h0010, 1'b0, 16'd0, 1'b1, 64'd2,    1'b0},
		'{1'b0, 16'd3,     16'd3,      16'h0000, 1'b0, 16'd4, 1'b0, 64'd0,    1'b0},
		'{1'b1, 16'd1,     16'd5,      16'h0000, 1'b0, 16'd0, 1'b1, 64'd1,    1'b0},
		'{1'b1, 16'd5,     16'd1,      16'h0000, 1'b0, 16'd0, 1'b1, 64'd1,    1'b0},
		'{1'b0, 16'd5,     16'd1,      16'h0004, 1'b0, 16'd0, 1'b1, 64'd0,    1'b0},
		'{1'b1, 16'd2,     16'd2,      16'h0006, 1'b0, 16'd0, 1'b1, 64'd0,    1'b0},
		'{1'b1, 16'd4,     16'd4,      16'h0240, 1'b0, 16'd0, 1'b0, 64'd0,    1'b0},
		'{1'b1, 16'd2,     16'hFF03,   16'h0000, 1'b0, 16'd0, 1'b0, 64'd0,    1'b0},
		'{1'b1, 16'd1,     16'd255,    16'h0000, 1'b0, 16'd0, 1'b0, 64'd0,    1'b0},
		'{1'b1, 16'd1,     16'd129,    16'h0102, 1'b0, 16'd0, 1'b0, 64'd0,    1'b0},
		'{1'b1, 16'd6,     16'd6,      16'h0000, 1'b0, 16'd0, 1'b0, 64'd0,    1'b0},
		'{1'b1, 16'd35,    16'd35,     16'h0000, 1'b0, 16'd0, 1'b1, ALL_ONES, 1'b1},
		'{1'b1, 16'd2,     16'd2,      16'h0000, 1'b0, 16'd0, 1'b1, 64'd2,    1'b0},
		'{1'b1, 16'd65535, 16'd1,      16'h0000, 1'b0, 16'd8, 1'b0, 64'd0,    1'b0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [IDX_W-1:0]     cfg_index = gpc_pkg::REG_ROWS;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic                 blocked   = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PATH_W-1:0]    path_count;
	logic                 saturated;

	// path count predictor state
	logic [ROWS_W-1:0]    rows_cfg = 16'd1;
	logic [COLS_W-1:0]    cols_cfg = 8'd1;
	logic [PATH_W-1:0]    col_counts [MAX_COLS];
	logic [PATH_W-1:0]    left_cnt;
	int unsigned          col_pos;
	int unsigned          row_pos;
	logic                 clip_flag;

	gpc_pkg::res_t        pending_counts [$];
	gpc_pkg::res_t        typed_res;
	bit                   typed_armed = 1'b0;
	gpc_pkg::res_t        want;

	int                   in_idle_pct  = 24;
	int                   out_idle_pct = 82;
	int                   errors    = 0;
	int                   n_cells   = 0;
	int                   n_cfgs    = 0;
	int                   n_results = 0;
	int                   n_sat     = 0;

	grid_path_count_with_obstacles_top #(
		.MAX_COLS  (MAX_COLS),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.blocked   (blocked),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.path_count(path_count),
		.saturated (saturated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	function automatic int unsigned rows_used();
		return (rows_cfg == 0) ? 1 : rows_cfg;
	endfunction

	function automatic int unsigned cols_used();
		if (cols_cfg == 0)
			return 1;
		return (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
	endfunction

	function automatic int grid_cells();
		return rows_used() * cols_used();
	endfunction

	function automatic void restart_grid();
		left_cnt  = '0;
		col_pos   = 0;
		row_pos   = 0;
		clip_flag = 1'b0;
	endfunction

	// One cell of the row-major walk; pushes the grid's count after its last cell.
	task automatic tally_cell(input logic blk);
		int unsigned       cn;
		int unsigned       rn;
		int unsigned       c;
		logic [PATH_W-1:0] up;
		logic [PATH_W-1:0] lf;
		logic [PATH_W-1:0] val;
		logic [PATH_W:0]   sum;
		gpc_pkg::res_t     got;
		cn = cols_used();
		rn = rows_used();
		c  = (col_pos >= cn) ? 0 : col_pos;
		up = (row_pos == 0) ? '0 : col_counts[c];
		lf = (c == 0) ? '0 : left_cnt;
		if (blk) begin
			val = '0;
		end else if (row_pos == 0 && c == 0) begin
			val = PATH_W'(1);
		end else begin
			sum = {1'b0, up} + {1'b0, lf};
			if (sum[PATH_W]) begin
				val       = ALL_ONES;
				clip_flag = 1'b1;
			end else begin
				val = sum[PATH_W-1:0];
			end
		end
		col_counts[c] = val;
		left_cnt      = val;
		if (c + 1 >= cn) begin
			col_pos  = 0;
			left_cnt = '0;
			if (row_pos + 1 >= rn) begin
				got.count = val;
				got.sat   = clip_flag;
				if (typed_armed)
					got = typed_res;
				typed_armed = 1'b0;
				pending_counts.push_back(got);
				restart_grid();
			end else begin
				row_pos++;
			end
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic send_cell(input logic blk);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		blocked  <= blk;
		do @(posedge clk); while (in_stall);
		n_cells++;
		tally_cell(blk);
	endtask

	// all counts back, plus room for a partial grid still in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= gpc_pkg::REG_ROWS;
		cfg_data  <= r;
		@(posedge clk);
		rows_cfg = r[ROWS_W-1:0];
		restart_grid();
		cfg_index <= gpc_pkg::REG_COLS;
		cfg_data  <= c;
		@(posedge clk);
		cols_cfg = c[COLS_W-1:0];
		restart_grid();
		cfg_we <= 1'b0;
		n_cfgs++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_counts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: expected none, got count=%0d sat=%0b",
					$time, path_count, saturated);
			end else begin
				want = pending_counts.pop_front();
				n_results++;
				if (saturated)
					n_sat++;
				if (path_count !== want.count) begin
					errors++;
					$display("%0t: path_count mismatch: expected %0d, got %0d",
						$time, want.count, path_count);
				end
				if (saturated !== want.sat) begin
					errors++;
					$display("%0t: saturated mismatch: expected %0b, got %0b",
						$time, want.sat, saturated);
				end
			end
		end
	end

	initial begin
		int                 ph;
		int                 i;
		int                 k;
		int                 total;
		int                 n;
		int                 blk_pct;
		int                 start_cells;
		bit                 must_write;
		logic [CFG_W-1:0]   rcfg;
		logic [CFG_W-1:0]   ccfg;
		restart_grid();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		must_write = 1'b0;
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					in_idle_pct  = 24;
					out_idle_pct = 82;
				end
				1: begin
					in_idle_pct  = 82;
					out_idle_pct = 24;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase

			if (ph == 0) begin
				for (i = 0; i < N_CASES; i++) begin
					if (GRID_CASES[i].wr)
						write_regs(GRID_CASES[i].rows, GRID_CASES[i].cols);
					typed_armed     = GRID_CASES[i].known;
					typed_res.count = GRID_CASES[i].cnt;
					typed_res.sat   = GRID_CASES[i].sat;
					total = grid_cells();
					n     = (GRID_CASES[i].cut != 0) ? GRID_CASES[i].cut : total;
					for (k = 0; k < n; k++)
						send_cell(((k < 16) && GRID_CASES[i].cells[k[3:0]]) ||
							(GRID_CASES[i].last_blk && k == total - 1));
				end
				// the last table grid is left unfinished on a tall geometry
				must_write = 1'b1;
			end

			start_cells = n_cells;
			while (n_cells < start_cells + RAND_BEATS) begin
				if (must_write || $urandom_range(3) == 0) begin
					case ($urandom_range(9))
						0: rcfg = 16'd0;
						1: rcfg = 16'($urandom_range(7, 12));
						default: rcfg = 16'($urandom_range(1, 5));
					endcase
					case ($urandom_range(9))
						0: ccfg = 16'd0;
						1: begin
							ccfg = 16'($urandom_range(129, 255));
							rcfg = 16'($urandom_range(0, 2));
						end
						2: ccfg = {8'($urandom), 8'($urandom_range(1, 6))};
						default: ccfg = 16'($urandom_range(1, 6));
					endcase
					write_regs(rcfg, ccfg);
					must_write = 1'b0;
				end
				blk_pct = $urandom_range(1) ? 12 : 45;
				total   = grid_cells();
				// now and then drop a grid part way; the next register write restarts it
				n = ($urandom_range(9) == 0) ? $urandom_range(1, total) : total;
				must_write = (n < total);
				for (k = 0; k < n; k++)
					send_cell($urandom_range(99) < blk_pct);
			end
		end

		wait_idle();
		$display("Fed %0d cells under %0d register settings; %0d path counts checked, %0d saturated.",
			n_cells, n_cfgs, n_results, n_sat);
		$display("Sender-heavy, receiver-heavy and gap-free idling phases were run.");
		if (errors == 0 && pending_counts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
